// ===== hw/rtl/twl_pkg.sv =====
// ----------------------------------------------------------------------------
// twl_pkg: shared types and constants for the three-letter word lookup
// Holds the word mode codes, the bucket descriptor layout and the
// one-hot sequencer states.
// ----------------------------------------------------------------------------
package twl_pkg;

	// Number of buckets, one per lower-case letter.
	localparam int LETTERS = 26;

	// Character range of a valid first letter.
	localparam logic [7:0] CHAR_LO = 8'h61;
	localparam logic [7:0] CHAR_HI = 8'h7A;

	// Field widths of the word.
	localparam int START_W = 11;
	localparam int COUNT_W = 12;
	localparam int KEY_W   = 16;

	// Word mode codes.
	localparam logic [1:0] MODE_DESC  = 2'd0;
	localparam logic [1:0] MODE_ENTRY = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	// One bucket descriptor: first suffix address and entry count.
	typedef struct packed {
		logic [START_W-1:0] start;
		logic [COUNT_W-1:0] count;
	} bucket_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_REDUCE = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

endpackage

// ===== hw/rtl/three_letter_word_lookup.sv =====
// ----------------------------------------------------------------------------
// three_letter_word_lookup: bucketed dictionary search for 3-letter words
// Every request word gives one response word. Mode 0 writes a bucket
// descriptor, mode 1 writes a suffix entry, mode 2 looks up a word.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req_valid/req_stall with one field per port; responses
// leave on rsp_valid/rsp_stall carrying found. A word moves on a channel at
// a rising edge where valid is high and stall is low.
// Load words and lookups whose first character is not 'a' to 'z' skip the
// scan and answer found = 0. A lookup first folds the bucket start into
// the suffix memory range with a compare/subtract unit, then reads the
// suffix memory one entry per cycle through its single registered read
// port, stopping early on a hit.
// The block holds req_stall high while a word is in progress. A finished
// response sits in an output register, so a new request is taken while
// the response waits; a later response waits until that one is taken.
// Reset empties every bucket (start and count zero) and clears the
// response register. The suffix memory is not cleared; its entries are
// undefined until written.
// ----------------------------------------------------------------------------
module three_letter_word_lookup #(
	parameter int WORDS = 2048
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [1:0]                mode,
	input  logic [7:0]                first_char,
	input  logic [7:0]                second_char,
	input  logic [7:0]                third_char,
	input  logic [4:0]                bucket_index,
	input  logic [10:0]               entry_address,
	input  logic [10:0]               bucket_start,
	input  logic [11:0]               bucket_count,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic                      found
);

	import twl_pkg::*;

	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PW    = (AW > START_W) ? AW : START_W;
	localparam int CLAMP = (WORDS > 4095) ? 4095 : WORDS;
	localparam logic [PW:0]        WORDS_W = (PW+1)'(WORDS);
	localparam logic [COUNT_W-1:0] CLAMP_W = COUNT_W'(CLAMP);

	state_t              state_q;
	bucket_t             table_q [LETTERS];
	logic [KEY_W-1:0]    mem_q [WORDS];
	logic [KEY_W-1:0]    rd_data_q;
	logic                rd_vld_q;
	logic [KEY_W-1:0]    key_q;
	logic [PW-1:0]       addr_q;
	logic [COUNT_W-1:0]  left_q;
	logic                res_q;
	logic                out_vld_q;
	logic                out_found_q;

	logic                req_take;
	logic                is_letter;
	logic [4:0]          letter;
	bucket_t             sel;
	logic [COUNT_W-1:0]  sel_count;
	logic [PW:0]         addr_ext;
	logic                addr_high;
	logic [PW:0]         addr_dec;
	logic [PW:0]         addr_inc;
	logic [PW-1:0]       addr_next;
	logic                hit;
	logic                issue;
	logic                entry_ok;
	logic [PW-1:0]       eaddr_w;
	logic                wr_en;
	logic                rsp_free;

	// Request handshake and first-letter decode.
	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign is_letter = (first_char >= CHAR_LO) && (first_char <= CHAR_HI);
	assign letter    = 5'(first_char - CHAR_LO);
	assign sel       = table_q[is_letter ? letter : 5'd0];
	assign sel_count = (sel.count > CLAMP_W) ? CLAMP_W : sel.count;

	// Compare/subtract unit and wrapping increment for the scan address.
	assign addr_ext  = {1'b0, addr_q};
	assign addr_high = (addr_ext >= WORDS_W);
	assign addr_dec  = addr_ext - WORDS_W;
	assign addr_inc  = addr_ext + (PW+1)'(1);
	assign addr_next = (addr_inc == WORDS_W) ? '0 : addr_inc[PW-1:0];

	// Scan step: compare the entry read last cycle, issue the next read.
	assign hit   = rd_vld_q && (rd_data_q == key_q);
	assign issue = (state_q == ST_SCAN) && !hit && (left_q != '0);

	// Suffix entry writes that fall inside the memory.
	assign eaddr_w  = PW'(entry_address);
	assign entry_ok = ({1'b0, eaddr_w} < WORDS_W);
	assign wr_en    = req_take && (mode == MODE_ENTRY) && entry_ok;

	// Response register can load when empty or being drained.
	assign rsp_free = !out_vld_q || !rsp_stall;

	// Suffix memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[eaddr_w[AW-1:0]] <= {second_char, third_char};
		end
		if (issue) begin
			rd_data_q <= mem_q[addr_q[AW-1:0]];
		end
	end

	// Bucket descriptor table, emptied by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LETTERS; i++) begin
				table_q[i] <= '0;
			end
		end else if (req_take && (mode == MODE_DESC) && (bucket_index < 5'(LETTERS))) begin
			table_q[bucket_index] <= '{start: bucket_start, count: bucket_count};
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_vld_q <= 1'b0;
			res_q    <= 1'b0;
			key_q    <= '0;
			addr_q   <= '0;
			left_q   <= '0;
		end else begin
			rd_vld_q <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						res_q  <= 1'b0;
						key_q  <= {second_char, third_char};
						addr_q <= PW'(sel.start);
						left_q <= sel_count;
						if ((mode == MODE_QUERY) && is_letter) begin
							state_q <= ST_REDUCE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_REDUCE: begin
					if (addr_high) begin
						addr_q <= addr_dec[PW-1:0];
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						res_q   <= 1'b1;
						state_q <= ST_DONE;
					end else if (left_q == '0) begin
						if (!rd_vld_q) begin
							state_q <= ST_DONE;
						end
					end else begin
						addr_q <= addr_next;
						left_q <= left_q - COUNT_W'(1);
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Response output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			out_found_q <= 1'b0;
		end else if ((state_q == ST_DONE) && rsp_free) begin
			out_vld_q   <= 1'b1;
			out_found_q <= res_q;
		end else if (out_vld_q && !rsp_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	assign rsp_valid = out_vld_q;
	assign found     = out_found_q;

`ifndef SYNTHESIS
	// A pending memory read is only ever issued from the scan state.
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_q |-> $past(state_q == ST_SCAN))
		else $error("suffix read pending outside scan");

	// During the scan the address has been folded into the memory range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !addr_high)
		else $error("scan address beyond suffix memory");

	// A new response appears only when the sequencer finishes a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(out_vld_q) && out_vld_q) |-> $past(state_q == ST_DONE))
		else $error("response without finished word");

	// A hit during the scan sets the result and ends in the done state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(hit && (state_q == ST_SCAN)) |=> (res_q && (state_q == ST_DONE)))
		else $error("hit not reported");
`endif

endmodule
